[sv/v4a_pkg.sv]
// v4a_pkg: shared types, opcodes and helpers of the four-component vector unit
// no dependencies; imported by v4a_front, v4a_div, v4a_back and vec4_arith_unit
`default_nettype none

package v4a_pkg;

   localparam int WORD_W            = 32;
   localparam int LANES             = 4;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int MID_DEPTH         = 2;
   localparam int RSP_DEPTH         = 2;
   localparam int WIDE_W            = 66;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   localparam wide_type MAX_WORD = wide_type'(64'sd2147483647);
   localparam wide_type MIN_WORD = -wide_type'(64'sd2147483648);

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_SUB    = 3'd1,
      OP_SCALE  = 3'd2,
      OP_DOT    = 3'd3,
      OP_LENGTH = 3'd4,
      OP_NORM   = 3'd5,
      OP_EQUAL  = 3'd6
   } op_type;

   typedef struct packed {
      logic add;
      logic sub;
      logic scale;
      logic dot;
      logic length;
      logic norm;
      logic equal;
      logic bad;
   } op_class_type;

   typedef struct packed {
      op_class_type             cls;
      word_type [LANES-1:0]     a;
      word_type [LANES-1:0]     b;
      word_type                 s;
   } item_type;

   typedef struct packed {
      word_type [LANES-1:0] r;
      word_type             scalar;
      logic                 equal;
      logic                 error;
   } rsp_type;

   typedef struct packed {
      logic     ovf;
      word_type val;
   } sat_type;

   function automatic sat_type sat_word(input wide_type v);
      sat_type res;
      res.ovf = 1'b0;
      res.val = word_type'(v);
      if (v > MAX_WORD) begin
         res.ovf = 1'b1;
         res.val = word_type'(MAX_WORD);
      end else if (v < MIN_WORD) begin
         res.ovf = 1'b1;
         res.val = word_type'(MIN_WORD);
      end
      return res;
   endfunction

   function automatic op_class_type classify(input logic [2:0] code);
      op_class_type cls;
      cls = '0;
      case (op_type'(code))
         OP_ADD:    cls.add    = 1'b1;
         OP_SUB:    cls.sub    = 1'b1;
         OP_SCALE:  cls.scale  = 1'b1;
         OP_DOT:    cls.dot    = 1'b1;
         OP_LENGTH: cls.length = 1'b1;
         OP_NORM:   cls.norm   = 1'b1;
         OP_EQUAL:  cls.equal  = 1'b1;
         default:   cls.bad    = 1'b1;
      endcase
      return cls;
   endfunction

endpackage

`default_nettype wire

[sv/v4a_fifo.sv]
// v4a_fifo: small register queue with push/full and pop/empty sides
// depends on nothing but its parameters; used between front and back and at the result side
`default_nettype none

module v4a_fifo #(
   parameter int  DEPTH     = 2,
   parameter type data_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  data_type push_data,
   output logic     full,
   input  logic     pop,
   output data_type pop_data,
   output logic     empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   data_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push_ok, pop_ok;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (!push_ok && pop_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      push_ok && !pop_ok |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");

endmodule

`default_nettype wire

[sv/v4a_front.sv]
// v4a_front: takes request transactions, decodes the opcode into an operation class
// depends on v4a_pkg; feeds the queue in front of v4a_back
`default_nettype none

module v4a_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [2:0]         req_opcode,
   input  v4a_pkg::word_type  req_a_x,
   input  v4a_pkg::word_type  req_a_y,
   input  v4a_pkg::word_type  req_a_z,
   input  v4a_pkg::word_type  req_a_w,
   input  v4a_pkg::word_type  req_b_x,
   input  v4a_pkg::word_type  req_b_y,
   input  v4a_pkg::word_type  req_b_z,
   input  v4a_pkg::word_type  req_b_w,
   input  v4a_pkg::word_type  req_scale_factor,
   output logic               mid_push,
   output v4a_pkg::item_type  mid_item,
   input  logic               mid_full
);
   import v4a_pkg::*;

   logic     vld_ff, vld_in, load;
   item_type item_ff, item_in;

   assign load     = !vld_ff || !mid_full;
   assign req_full = !load;
   assign mid_push = vld_ff && !mid_full;
   assign mid_item = item_ff;
   assign vld_in   = load ? req_push : vld_ff;

   always_comb begin
      item_in.cls = classify(req_opcode);
      item_in.a   = {req_a_w, req_a_z, req_a_y, req_a_x};
      item_in.b   = {req_b_w, req_b_z, req_b_y, req_b_x};
      item_in.s   = req_scale_factor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_push) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

[sv/v4a_root.sv]
// v4a_root: pipelined integer square root, one root bit per stage, rounded to nearest
// depends on nothing but its parameters; carries a side record alongside each value
`default_nettype none

module v4a_root #(
   parameter int  XW        = 66,
   parameter type side_type = logic
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  logic [XW-1:0]     in_x,
   input  side_type          in_side,
   output logic              out_vld,
   output logic [XW/2-1:0]   out_len,
   output side_type          out_side
);
   localparam int RW = XW / 2;
   localparam int MW = RW + 2;

   logic            vld_ff  [RW+1];
   side_type        side_ff [RW+1];
   logic [XW-1:0]   x_ff    [RW];
   logic [MW-1:0]   rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [RW-1:0]   len_ff, len_in;

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic          vld_prev;
      side_type      side_prev;
      logic [XW-1:0] x_prev;
      logic [MW-1:0] rem_prev, cur, trial, rem_in;
      logic [RW-1:0] root_prev, root_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign side_prev = in_side;
         assign x_prev    = in_x;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign x_prev    = x_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      always_comb begin
         cur   = {rem_prev[MW-3:0], x_prev[XW-1 -: 2]};
         trial = {root_prev, 2'b01};
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {root_prev[RW-2:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {root_prev[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_prev;
            x_ff[k]    <= x_prev << 2;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   // round to nearest: remainder above the root means the half point was passed
   assign len_in = root_ff[RW-1] + RW'(rem_ff[RW-1] > {2'b00, root_ff[RW-1]});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[RW] <= 1'b0;
      end else if (en) begin
         vld_ff[RW] <= vld_ff[RW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[RW] <= side_ff[RW-1];
         len_ff      <= len_in;
      end
   end

   assign out_vld  = vld_ff[RW];
   assign out_len  = len_ff;
   assign out_side = side_ff[RW];

endmodule

`default_nettype wire

[sv/v4a_div.sv]
// v4a_div: pipelined restoring divider, four lanes sharing one divisor, one quotient bit per stage
// depends on v4a_pkg; carries a side record alongside each transaction
`default_nettype none

module v4a_div #(
   parameter int  QW        = 17,
   parameter int  DW        = 34,
   parameter type side_type = logic
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_vld,
   input  logic [v4a_pkg::LANES-1:0][DW+QW-1:0]   in_num,
   input  logic [DW-1:0]                          in_den,
   input  side_type                               in_side,
   output logic                                   out_vld,
   output logic [v4a_pkg::LANES-1:0][QW-1:0]      out_q,
   output side_type                               out_side
);
   import v4a_pkg::*;

   localparam int NW = DW + QW;

   logic            vld_ff  [QW];
   side_type        side_ff [QW];
   logic [DW-1:0]   den_ff  [QW];
   logic [NW-1:0]   rem_ff  [QW][LANES];
   logic [QW-1:0]   q_ff    [QW][LANES];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int BIT = QW - 1 - k;

      logic                     vld_prev;
      side_type                 side_prev;
      logic [DW-1:0]            den_prev;
      logic [NW-1:0]            rem_prev [LANES];
      logic [QW-1:0]            q_prev   [LANES];
      logic [NW-1:0]            rem_in   [LANES];
      logic [QW-1:0]            q_in     [LANES];
      logic [NW-1:0]            dsh;

      if (k == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign side_prev = in_side;
         assign den_prev  = in_den;
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign rem_prev[l] = in_num[l];
            assign q_prev[l]   = '0;
         end
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign den_prev  = den_ff[k-1];
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign rem_prev[l] = rem_ff[k-1][l];
            assign q_prev[l]   = q_ff[k-1][l];
         end
      end

      assign dsh = NW'(den_prev) << BIT;

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            if (rem_prev[l] >= dsh) begin
               rem_in[l] = rem_prev[l] - dsh;
               q_in[l]   = q_prev[l] | (QW'(1) << BIT);
            end else begin
               rem_in[l] = rem_prev[l];
               q_in[l]   = q_prev[l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_prev;
            den_ff[k]  <= den_prev;
            for (int l = 0; l < LANES; l++) begin
               rem_ff[k][l] <= rem_in[l];
               q_ff[k][l]   <= q_in[l];
            end
         end
      end
   end

   assign out_vld  = vld_ff[QW-1];
   assign out_side = side_ff[QW-1];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_q[l] = q_ff[QW-1][l];
      end
   end

endmodule

`default_nettype wire

[sv/v4a_back.sv]
// v4a_back: execution pipeline: multiply, sum, round, square root and divide
// depends on v4a_pkg, v4a_root and v4a_div; drains the front queue, fills the result queue
`default_nettype none

module v4a_back #(
   parameter int FRAC_BITS = v4a_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               mid_empty,
   input  v4a_pkg::item_type  mid_item,
   output logic               mid_pop,
   input  logic               out_full,
   output logic               out_push,
   output v4a_pkg::rsp_type   out_rsp
);
   import v4a_pkg::*;

   localparam int XW = WIDE_W;
   localparam int RW = XW / 2;
   localparam int DW = RW + 1;
   localparam int QW = FRAC_BITS + 1;
   localparam int NW = DW + QW;
   localparam wide_type HALF = wide_type'(1) <<< (FRAC_BITS - 1);

   typedef logic signed [2*WORD_W-1:0] prod_type;
   typedef logic signed [2*WORD_W:0]   pair_type;

   typedef struct packed {
      op_class_type           cls;
      word_type [LANES-1:0]   a;
      prod_type [LANES-1:0]   prod;
      word_type [LANES-1:0]   r;
      logic                   equal;
      logic                   error;
   } s1_type;

   typedef struct packed {
      op_class_type           cls;
      word_type [LANES-1:0]   a;
      pair_type               pair0;
      pair_type               pair1;
      word_type [LANES-1:0]   r;
      logic                   equal;
      logic                   error;
   } s2_type;

   typedef struct packed {
      op_class_type           cls;
      word_type [LANES-1:0]   a;
      wide_type               total;
      word_type [LANES-1:0]   r;
      logic                   equal;
      logic                   error;
   } s3_type;

   typedef struct packed {
      op_class_type           cls;
      word_type [LANES-1:0]   a;
      word_type [LANES-1:0]   r;
      word_type               scalar;
      logic                   equal;
      logic                   error;
   } root_side_type;

   typedef struct packed {
      op_class_type           cls;
      word_type [LANES-1:0]   r;
      word_type               scalar;
      logic [LANES-1:0]       neg;
      logic                   zero;
      logic                   equal;
      logic                   error;
   } div_side_type;

   logic                        adv;
   logic                        s1_vld_ff, s2_vld_ff, s3_vld_ff;
   s1_type                      s1_ff, s1_in;
   s2_type                      s2_ff, s2_in;
   s3_type                      s3_ff, s3_in;
   root_side_type               rs_in, rs_out;
   logic                        root_vld;
   logic [RW-1:0]               root_len;
   div_side_type                ds_in, ds_out;
   logic [LANES-1:0][NW-1:0]    div_num;
   logic [DW-1:0]               div_den;
   logic                        div_vld;
   logic [LANES-1:0][QW-1:0]    div_q;
   logic                        out_vld_ff;
   rsp_type                     out_ff, out_in;

   assign adv      = !out_vld_ff || !out_full;
   assign mid_pop  = adv && !mid_empty;
   assign out_push = out_vld_ff && !out_full;
   assign out_rsp  = out_ff;

   // products, add and subtract, compare
   always_comb begin
      word_type m;
      sat_type  sv;
      s1_in.cls   = mid_item.cls;
      s1_in.a     = mid_item.a;
      s1_in.equal = mid_item.cls.equal && (mid_item.a == mid_item.b);
      s1_in.error = mid_item.cls.bad;
      for (int i = 0; i < LANES; i++) begin
         if (mid_item.cls.scale) begin
            m = mid_item.s;
         end else if (mid_item.cls.dot) begin
            m = mid_item.b[i];
         end else begin
            m = mid_item.a[i];
         end
         s1_in.prod[i] = prod_type'($signed(mid_item.a[i])) * prod_type'($signed(m));
         s1_in.r[i]    = '0;
         sv            = '0;
         if (mid_item.cls.add) begin
            sv = sat_word(wide_type'($signed(mid_item.a[i])) + wide_type'($signed(mid_item.b[i])));
         end else if (mid_item.cls.sub) begin
            sv = sat_word(wide_type'($signed(mid_item.a[i])) - wide_type'($signed(mid_item.b[i])));
         end
         if (mid_item.cls.add || mid_item.cls.sub) begin
            s1_in.r[i]  = sv.val;
            s1_in.error = s1_in.error | sv.ovf;
         end
      end
   end

   // pair sums, per-lane rounding for scale
   always_comb begin
      sat_type sv;
      s2_in.cls   = s1_ff.cls;
      s2_in.a     = s1_ff.a;
      s2_in.pair0 = pair_type'($signed(s1_ff.prod[0])) + pair_type'($signed(s1_ff.prod[1]));
      s2_in.pair1 = pair_type'($signed(s1_ff.prod[2])) + pair_type'($signed(s1_ff.prod[3]));
      s2_in.r     = s1_ff.r;
      s2_in.equal = s1_ff.equal;
      s2_in.error = s1_ff.error;
      for (int i = 0; i < LANES; i++) begin
         sv = sat_word((wide_type'($signed(s1_ff.prod[i])) + HALF) >>> FRAC_BITS);
         if (s1_ff.cls.scale) begin
            s2_in.r[i]  = sv.val;
            s2_in.error = s2_in.error | sv.ovf;
         end
      end
   end

   always_comb begin
      s3_in.cls   = s2_ff.cls;
      s3_in.a     = s2_ff.a;
      s3_in.total = wide_type'($signed(s2_ff.pair0)) + wide_type'($signed(s2_ff.pair1));
      s3_in.r     = s2_ff.r;
      s3_in.equal = s2_ff.equal;
      s3_in.error = s2_ff.error;
   end

   // dot rounding rides beside the root
   always_comb begin
      sat_type sv;
      sv           = sat_word((s3_ff.total + HALF) >>> FRAC_BITS);
      rs_in.cls    = s3_ff.cls;
      rs_in.a      = s3_ff.a;
      rs_in.r      = s3_ff.r;
      rs_in.scalar = '0;
      rs_in.equal  = s3_ff.equal;
      rs_in.error  = s3_ff.error;
      if (s3_ff.cls.dot) begin
         rs_in.scalar = sv.val;
         rs_in.error  = s3_ff.error | sv.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= !mid_empty;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   v4a_root #(
      .XW        (XW),
      .side_type (root_side_type)
   ) u_root (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (s3_vld_ff),
      .in_x     (s3_ff.total),
      .in_side  (rs_in),
      .out_vld  (root_vld),
      .out_len  (root_len),
      .out_side (rs_out)
   );

   // length result, divider operands for normalize
   always_comb begin
      logic [WORD_W-1:0] mag;
      ds_in.cls    = rs_out.cls;
      ds_in.r      = rs_out.r;
      ds_in.scalar = rs_out.scalar;
      ds_in.equal  = rs_out.equal;
      ds_in.error  = rs_out.error;
      ds_in.zero   = (root_len == '0);
      div_den      = {root_len, 1'b0};
      for (int i = 0; i < LANES; i++) begin
         ds_in.neg[i] = rs_out.a[i][WORD_W-1];
         mag          = rs_out.a[i][WORD_W-1] ? (~rs_out.a[i] + 1'b1) : rs_out.a[i];
         div_num[i]   = (NW'(mag) << (FRAC_BITS + 1)) + NW'(root_len);
      end
      if (rs_out.cls.length) begin
         if (root_len[RW-1:WORD_W-1] != '0) begin
            ds_in.scalar = word_type'(MAX_WORD);
            ds_in.error  = 1'b1;
         end else begin
            ds_in.scalar = word_type'(root_len);
         end
      end
      if (rs_out.cls.norm && ds_in.zero) begin
         ds_in.error = 1'b1;
      end
   end

   v4a_div #(
      .QW        (QW),
      .DW        (DW),
      .side_type (div_side_type)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (root_vld),
      .in_num   (div_num),
      .in_den   (div_den),
      .in_side  (ds_in),
      .out_vld  (div_vld),
      .out_q    (div_q),
      .out_side (ds_out)
   );

   always_comb begin
      word_type qw;
      out_in.r      = ds_out.r;
      out_in.scalar = ds_out.scalar;
      out_in.equal  = ds_out.equal;
      out_in.error  = ds_out.error;
      for (int i = 0; i < LANES; i++) begin
         qw = word_type'(div_q[i]);
         if (ds_out.cls.norm) begin
            if (ds_out.zero) begin
               out_in.r[i] = '0;
            end else begin
               out_in.r[i] = ds_out.neg[i] ? -qw : qw;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_full |=> out_vld_ff && $stable(out_ff))
      else $error("result changed while stalled");

   a_equal_no_error: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !(out_rsp.equal && out_rsp.error))
      else $error("compare transaction flagged an error");

   a_scalar_alone: assert property (@(posedge clock) disable iff (reset)
      out_push && (out_rsp.scalar != '0) |-> (out_rsp.r == '0) && !out_rsp.equal)
      else $error("scalar result mixed with vector result");

endmodule

`default_nettype wire

[sv/vec4_arith_unit.sv]
// vec4_arith_unit: four-component Q-format vector unit, top level
// depends on v4a_pkg, v4a_front, v4a_fifo, v4a_back
//
//   channel | ports                          | handshake
//   request | req_opcode, req_a_*, req_b_*,  | push / full
//           | req_scale_factor               |
//   result  | rsp_r_*, rsp_scalar_out,       | empty / pop
//           | rsp_equal_flag, rsp_error_flag |
//
// one transaction accepted per cycle while req_full is low, results in order, one per transaction
// the path from accept to the earliest pop runs through the front register and queue,
// the back stages, the square root and the FRAC_BITS + 1 stage divider
// reset clears valid state and queues only; the result side stalls the whole
// back pipeline, the request side then fills the front queue before full rises
`default_nettype none

module vec4_arith_unit #(
   parameter int FRAC_BITS = v4a_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [2:0]         req_opcode,
   input  v4a_pkg::word_type  req_a_x,
   input  v4a_pkg::word_type  req_a_y,
   input  v4a_pkg::word_type  req_a_z,
   input  v4a_pkg::word_type  req_a_w,
   input  v4a_pkg::word_type  req_b_x,
   input  v4a_pkg::word_type  req_b_y,
   input  v4a_pkg::word_type  req_b_z,
   input  v4a_pkg::word_type  req_b_w,
   input  v4a_pkg::word_type  req_scale_factor,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output v4a_pkg::word_type  rsp_r_x,
   output v4a_pkg::word_type  rsp_r_y,
   output v4a_pkg::word_type  rsp_r_z,
   output v4a_pkg::word_type  rsp_r_w,
   output v4a_pkg::word_type  rsp_scalar_out,
   output logic               rsp_equal_flag,
   output logic               rsp_error_flag
);
   import v4a_pkg::*;

   logic     mid_push, mid_full, mid_pop, mid_empty;
   item_type mid_in, mid_out;
   logic     back_push, back_full;
   rsp_type  back_rsp, rsp_head;

   v4a_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_opcode       (req_opcode),
      .req_a_x          (req_a_x),
      .req_a_y          (req_a_y),
      .req_a_z          (req_a_z),
      .req_a_w          (req_a_w),
      .req_b_x          (req_b_x),
      .req_b_y          (req_b_y),
      .req_b_z          (req_b_z),
      .req_b_w          (req_b_w),
      .req_scale_factor (req_scale_factor),
      .mid_push         (mid_push),
      .mid_item         (mid_in),
      .mid_full         (mid_full)
   );

   v4a_fifo #(
      .DEPTH     (MID_DEPTH),
      .data_type (item_type)
   ) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_out),
      .empty     (mid_empty)
   );

   v4a_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_item  (mid_out),
      .mid_pop   (mid_pop),
      .out_full  (back_full),
      .out_push  (back_push),
      .out_rsp   (back_rsp)
   );

   v4a_fifo #(
      .DEPTH     (RSP_DEPTH),
      .data_type (rsp_type)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_rsp),
      .full      (back_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_r_x        = rsp_head.r[0];
   assign rsp_r_y        = rsp_head.r[1];
   assign rsp_r_z        = rsp_head.r[2];
   assign rsp_r_w        = rsp_head.r[3];
   assign rsp_scalar_out = rsp_head.scalar;
   assign rsp_equal_flag = rsp_head.equal;
   assign rsp_error_flag = rsp_head.error;

endmodule

`default_nettype wire
